// ----- rtl/core/structured_grid_cell_generator_top_defines.svh -----
// Assertion macros shared by the structured grid cell generator RTL.
`ifndef STRUCTURED_GRID_CELL_GENERATOR_TOP_DEFINES_SVH
`define STRUCTURED_GRID_CELL_GENERATOR_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SGCG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sgcg: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SGCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sgcg: next-cycle check failed");

`endif

// ----- rtl/core/sgcg_pkg.sv -----
// Types and constants shared by the structured grid cell generator.
`timescale 1ns / 1ps
package sgcg_pkg;

    localparam int DIM_W     = 11;
    localparam int NODE_W    = 30;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 2;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUAD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HEX  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

    typedef logic [NODE_W-1:0] t_node;

    // Walk geometry: strides and cell counts along the used axes, inner first.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_node             s0;
        t_node             s1;
        t_node             s2;
        t_node             s01;
        t_node             s02;
        t_node             s12;
        t_node             s012;
        logic [DIM_W-1:0]  len0;
        logic [DIM_W-1:0]  len1;
        logic [DIM_W-1:0]  len2;
    } t_geom;

    localparam t_geom GEOM_RESET = '{
        kind: KIND_NONE,
        s0: '0, s1: '0, s2: '0, s01: '0, s02: '0, s12: '0, s012: '0,
        len0: 11'd1, len1: 11'd1, len2: 11'd1
    };

    typedef struct packed {
        logic [KIND_W-1:0] cell_kind;
        t_node             node_a;
        t_node             node_b;
        t_node             node_c;
        t_node             node_d;
        t_node             node_e;
        t_node             node_f;
        t_node             node_g;
        t_node             node_h;
        logic              last_cell;
    } t_cell;

endpackage

// ----- rtl/core/structured_grid_cell_generator_top.sv -----
// Each transfer registers its cell in the output or, if that is held, the skid entry.
// Throughput: one cell per cycle; a two-entry output buffer keeps taking requests while a
// result waits, so the input stalls only when both entries are full, or while a
// dimension write restarts the walk and holds input ready low as the stride multiply
// and axis-selection registers refill.
// Reset (synchronous, active low): dims return to 1, walk and output buffer empty.
`timescale 1ns / 1ps
module structured_grid_cell_generator_top import sgcg_pkg::*; #(
    parameter int MAX_DIM = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_restart,
    // cell channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KIND_W-1:0]    o_cell_kind,
    output logic [NODE_W-1:0]    o_node_a,
    output logic [NODE_W-1:0]    o_node_b,
    output logic [NODE_W-1:0]    o_node_c,
    output logic [NODE_W-1:0]    o_node_d,
    output logic [NODE_W-1:0]    o_node_e,
    output logic [NODE_W-1:0]    o_node_f,
    output logic [NODE_W-1:0]    o_node_g,
    output logic [NODE_W-1:0]    o_node_h,
    output logic                 o_last_cell
);

    t_geom w_geom;
    t_cell w_cell;
    t_cell w_out_cell;
    logic  w_busy;
    logic  w_clear;
    logic  w_buf_ready;
    logic  w_xfer;

    // Request transfer: the walker advances and its cell enters the output buffer.
    assign o_in_ready = w_buf_ready && !w_busy;
    assign w_xfer     = i_in_valid && o_in_ready;

    sgcg_cfg #(
        .MAX_DIM(MAX_DIM)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_geom       (w_geom),
        .o_busy       (w_busy),
        .o_walk_clear (w_clear)
    );

    // Incremental base tracking: counters and row/plane bases advance by strides.
    sgcg_walker #(
        .MAX_DIM(MAX_DIM)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_clear   (w_clear),
        .i_step    (w_xfer),
        .i_restart (i_restart),
        .o_cell    (w_cell)
    );

    sgcg_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_xfer),
        .i_cell  (w_cell),
        .o_ready (w_buf_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_cell  (w_out_cell)
    );

    assign o_cell_kind = w_out_cell.cell_kind;
    assign o_node_a    = w_out_cell.node_a;
    assign o_node_b    = w_out_cell.node_b;
    assign o_node_c    = w_out_cell.node_c;
    assign o_node_d    = w_out_cell.node_d;
    assign o_node_e    = w_out_cell.node_e;
    assign o_node_f    = w_out_cell.node_f;
    assign o_node_g    = w_out_cell.node_g;
    assign o_node_h    = w_out_cell.node_h;
    assign o_last_cell = w_out_cell.last_cell;

endmodule

// ----- rtl/core/sgcg_cfg.sv -----
// Dimension registers and the registered geometry derived from them.
`timescale 1ns / 1ps
module sgcg_cfg import sgcg_pkg::*; #(
    parameter int MAX_DIM = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output t_geom                o_geom,
    output logic                 o_busy,
    output logic                 o_walk_clear
);

    localparam int unsigned     DIM_CAP   = (MAX_DIM < 2047) ? MAX_DIM : 2047;
    localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);

    logic [DIM_W-1:0]   r_dim_x, r_dim_y, r_dim_z;
    logic [DIM_W-1:0]   r_d0, r_d1, r_d2;
    logic [DIM_W-1:0]   n_d0, n_d1, n_d2;
    logic [2*DIM_W-1:0] r_p, n_p;
    t_geom              r_geom, n_geom;
    logic [1:0]         r_settle;
    logic               w_hit;

    always_comb begin
        unique case (i_cfg_idx)
            REG_DIM_X, REG_DIM_Y, REG_DIM_Z: w_hit = 1'b1;
            default:                         w_hit = 1'b0;
        endcase
    end

    assign o_walk_clear = i_cfg_we && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= DIM_W'(1);
            r_dim_y <= DIM_W'(1);
            r_dim_z <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DIM_X: r_dim_x <= i_cfg_data;
                REG_DIM_Y: r_dim_y <= i_cfg_data;
                REG_DIM_Z: r_dim_z <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Effective dims: zero reads as one, oversized clamps to the cap.
    always_comb begin
        n_d0 = (r_dim_x == '0) ? DIM_W'(1) : ((r_dim_x > DIM_CAP_V) ? DIM_CAP_V : r_dim_x);
        n_d1 = (r_dim_y == '0) ? DIM_W'(1) : ((r_dim_y > DIM_CAP_V) ? DIM_CAP_V : r_dim_y);
        n_d2 = (r_dim_z == '0) ? DIM_W'(1) : ((r_dim_z > DIM_CAP_V) ? DIM_CAP_V : r_dim_z);
        n_p  = {{DIM_W{1'b0}}, n_d0} * {{DIM_W{1'b0}}, n_d1};
    end

    always_comb begin
        t_node       st1;
        t_node       st2;
        logic [2:0]  used;
        st1    = NODE_W'(r_d0);
        st2    = NODE_W'(r_p);
        used   = {r_d2 > DIM_W'(1), r_d1 > DIM_W'(1), r_d0 > DIM_W'(1)};
        n_geom = GEOM_RESET;
        unique case (used)
            3'b000: ;
            3'b001: begin
                n_geom.kind = KIND_LINE; n_geom.s0 = NODE_W'(1); n_geom.len0 = r_d0 - 1'b1;
            end
            3'b010: begin
                n_geom.kind = KIND_LINE; n_geom.s0 = st1; n_geom.len0 = r_d1 - 1'b1;
            end
            3'b100: begin
                n_geom.kind = KIND_LINE; n_geom.s0 = st2; n_geom.len0 = r_d2 - 1'b1;
            end
            3'b011: begin
                n_geom.kind = KIND_QUAD; n_geom.s0 = NODE_W'(1); n_geom.s1 = st1;
                n_geom.len0 = r_d0 - 1'b1; n_geom.len1 = r_d1 - 1'b1;
            end
            3'b101: begin
                n_geom.kind = KIND_QUAD; n_geom.s0 = NODE_W'(1); n_geom.s1 = st2;
                n_geom.len0 = r_d0 - 1'b1; n_geom.len1 = r_d2 - 1'b1;
            end
            3'b110: begin
                n_geom.kind = KIND_QUAD; n_geom.s0 = st1; n_geom.s1 = st2;
                n_geom.len0 = r_d1 - 1'b1; n_geom.len1 = r_d2 - 1'b1;
            end
            3'b111: begin
                n_geom.kind = KIND_HEX; n_geom.s0 = NODE_W'(1); n_geom.s1 = st1;
                n_geom.s2 = st2;
                n_geom.len0 = r_d0 - 1'b1; n_geom.len1 = r_d1 - 1'b1;
                n_geom.len2 = r_d2 - 1'b1;
            end
        endcase
        n_geom.s01  = n_geom.s0 + n_geom.s1;
        n_geom.s02  = n_geom.s0 + n_geom.s2;
        n_geom.s12  = n_geom.s1 + n_geom.s2;
        n_geom.s012 = n_geom.s01 + n_geom.s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0     <= DIM_W'(1);
            r_d1     <= DIM_W'(1);
            r_d2     <= DIM_W'(1);
            r_p      <= (2*DIM_W)'(1);
            r_geom   <= GEOM_RESET;
            r_settle <= 2'b00;
        end else begin
            r_d0     <= n_d0;
            r_d1     <= n_d1;
            r_d2     <= n_d2;
            r_p      <= n_p;
            r_geom   <= n_geom;
            // Hold off transfers until the two derive stages reflect the write.
            r_settle <= o_walk_clear ? 2'b11 : {1'b0, r_settle[1]};
        end
    end

    assign o_geom = r_geom;
    assign o_busy = |r_settle;

endmodule

// ----- rtl/core/sgcg_walker.sv -----
// Cell walk state and per-cell corner node generation.
`timescale 1ns / 1ps
`include "structured_grid_cell_generator_top_defines.svh"
module sgcg_walker import sgcg_pkg::*; #(
    parameter int MAX_DIM = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_geom i_geom,
    input  logic  i_clear,
    input  logic  i_step,
    input  logic  i_restart,
    output t_cell o_cell
);

    localparam int unsigned DIM_CAP = (MAX_DIM < 2047) ? MAX_DIM : 2047;
    localparam int          CNT_W   = $clog2(DIM_CAP);

    logic [CNT_W-1:0] r_c0, r_c1, r_c2, n_c0, n_c1, n_c2;
    t_node            r_base, r_row, r_plane, n_base, n_row, n_plane;
    logic             r_fin, n_fin;

    always_comb begin
        logic [CNT_W-1:0] c0, c1, c2;
        t_node            base, row, plane;
        logic             fin;
        logic [DIM_W:0]   inc0, inc1, inc2;
        logic             end0, end1, end2;
        c0    = i_restart ? '0 : r_c0;
        c1    = i_restart ? '0 : r_c1;
        c2    = i_restart ? '0 : r_c2;
        base  = i_restart ? '0 : r_base;
        row   = i_restart ? '0 : r_row;
        plane = i_restart ? '0 : r_plane;
        fin   = i_restart ? 1'b0 : r_fin;
        inc0  = (DIM_W+1)'(c0) + 1'b1;
        inc1  = (DIM_W+1)'(c1) + 1'b1;
        inc2  = (DIM_W+1)'(c2) + 1'b1;
        end0  = inc0 >= {1'b0, i_geom.len0};
        end1  = inc1 >= {1'b0, i_geom.len1};
        end2  = inc2 >= {1'b0, i_geom.len2};

        o_cell  = '0;
        n_c0    = c0;
        n_c1    = c1;
        n_c2    = c2;
        n_base  = base;
        n_row   = row;
        n_plane = plane;
        n_fin   = fin;

        if (i_geom.kind == KIND_NONE || fin) begin
            o_cell.cell_kind = KIND_NONE;
            o_cell.last_cell = 1'b1;
            n_fin            = 1'b1;
        end else begin
            o_cell.cell_kind = i_geom.kind;
            o_cell.node_a    = base;
            o_cell.node_b    = base + i_geom.s0;
            if (i_geom.kind != KIND_LINE) begin
                o_cell.node_c = base + i_geom.s01;
                o_cell.node_d = base + i_geom.s1;
            end
            if (i_geom.kind == KIND_HEX) begin
                o_cell.node_e = base + i_geom.s2;
                o_cell.node_f = base + i_geom.s02;
                o_cell.node_g = base + i_geom.s012;
                o_cell.node_h = base + i_geom.s12;
            end
            o_cell.last_cell = end0 && end1 && end2;
            if (end0 && end1 && end2) begin
                n_c0 = '0; n_c1 = '0; n_c2 = '0;
                n_base = '0; n_row = '0; n_plane = '0;
                n_fin  = 1'b1;
            end else if (!end0) begin
                n_c0   = CNT_W'(inc0);
                n_base = base + i_geom.s0;
            end else if (!end1) begin
                n_c0   = '0;
                n_c1   = CNT_W'(inc1);
                n_row  = row + i_geom.s1;
                n_base = n_row;
            end else begin
                n_c0    = '0;
                n_c1    = '0;
                n_c2    = CNT_W'(inc2);
                n_plane = plane + i_geom.s2;
                n_row   = n_plane;
                n_base  = n_plane;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0;
            r_base <= '0; r_row <= '0; r_plane <= '0;
            r_fin <= 1'b0;
        end else if (i_step) begin
            r_c0 <= n_c0; r_c1 <= n_c1; r_c2 <= n_c2;
            r_base <= n_base; r_row <= n_row; r_plane <= n_plane;
            r_fin <= n_fin;
        end
    end

    `SGCG_ASSERT_NEXT(a_fin_after_last, i_step && !i_clear && o_cell.last_cell, r_fin)
    `SGCG_ASSERT_NOW(a_cnt_in_range, !r_fin,
        ((DIM_W+1)'(r_c0) < (DIM_W+1)'(i_geom.len0)) &&
        ((DIM_W+1)'(r_c1) < (DIM_W+1)'(i_geom.len1)))

endmodule

// ----- rtl/core/sgcg_obuf.sv -----
// Output register with a skid stage so the walk keeps going while a result waits.
`timescale 1ns / 1ps
`include "structured_grid_cell_generator_top_defines.svh"
module sgcg_obuf import sgcg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cell i_cell,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    output t_cell o_cell
);

    t_cell r_out, r_skid;
    logic  r_out_v, r_skid_v;
    logic  w_take;

    assign w_take = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_v && !w_take) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_v && !w_take) begin
                r_skid <= i_cell;
            end else begin
                r_out <= i_cell;
            end
        end
    end

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_cell  = r_out;

    `SGCG_ASSERT_NOW(a_skid_needs_out, r_skid_v, r_out_v)
    `SGCG_ASSERT_NOW(a_no_push_when_full, i_push, !r_skid_v)
    `SGCG_ASSERT_NEXT(a_skid_drains, r_skid_v && i_ready, r_out_v && !r_skid_v)

endmodule
